[hw/rtl/ssw_pkg.sv]
// ----------------------------------------------------------------------------
// Selector shape weight package
// Shape codes, register indices and common types.
// ----------------------------------------------------------------------------
package ssw_pkg;

  typedef enum logic [2:0] {
    SHAPE_SQUARE   = 3'd0,
    SHAPE_RAMP_UP  = 3'd1,
    SHAPE_RAMP_DN  = 3'd2,
    SHAPE_TRIANGLE = 3'd3,
    SHAPE_ROUND    = 3'd4,
    SHAPE_SMOOTH   = 3'd5
  } shape_e;

  typedef enum logic [1:0] {
    REG_SHAPE_MODE  = 2'd0,
    REG_RANGE_START = 2'd1,
    REG_RANGE_END   = 2'd2
  } reg_idx_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ModeW   = 3;

endpackage

[hw/rtl/ssw_divider.sv]
// ----------------------------------------------------------------------------
// Selector shape weight divider
// Pipelined restoring divider that yields the quotient of a numerator shifted
// left by the fraction width and a denominator, BitsPerStage bits per stage.
// ----------------------------------------------------------------------------
module ssw_divider #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned BitsPerStage = 4,
  parameter int unsigned TagW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [FRAC_BITS:0]   num_i,
  input  logic [FRAC_BITS:0]   den_i,
  input  logic [TagW-1:0]      tag_i,
  output logic                 valid_o,
  output logic [FRAC_BITS:0]   quo_o,
  output logic [TagW-1:0]      tag_o
);

  localparam int unsigned W = FRAC_BITS + 1;
  localparam int unsigned Stages = (FRAC_BITS + BitsPerStage - 1) / BitsPerStage;

  logic [Stages:0]             vld_q;
  logic [W:0]                  rem_q [Stages+1];
  logic [FRAC_BITS-1:0]        quo_q [Stages+1];
  logic [W-1:0]                den_q [Stages+1];
  logic [TagW-1:0]             tag_q [Stages+1];

  // Stage 0 holds the integer remainder num (num < den always inside range).
  always_comb begin
    rem_q[0] = {1'b0, num_i};
    quo_q[0] = '0;
    den_q[0] = den_i;
    tag_q[0] = tag_i;
    vld_q[0] = valid_i;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [W:0]           rem_d;
    logic [FRAC_BITS-1:0] quo_d;
    logic [W:0]           rem_r;
    logic [FRAC_BITS-1:0] quo_r;
    logic [W-1:0]         den_r;
    logic [TagW-1:0]      tag_r;
    logic                 vld_r;

    always_comb begin
      logic [W+1:0] tr;
      rem_d = rem_q[s];
      quo_d = quo_q[s];
      for (int b = 0; b < BitsPerStage; b++) begin
        if (s * BitsPerStage + b < FRAC_BITS) begin
          tr = {rem_d, 1'b0};
          if (tr >= {2'b00, den_q[s]}) begin
            tr = tr - {2'b00, den_q[s]};
            quo_d = {quo_d[FRAC_BITS-2:0], 1'b1};
          end else begin
            quo_d = {quo_d[FRAC_BITS-2:0], 1'b0};
          end
          rem_d = tr[W:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_r <= 1'b0;
      end else if (adv_i) begin
        vld_r <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_r <= rem_d;
        quo_r <= quo_d;
        den_r <= den_q[s];
        tag_r <= tag_q[s];
      end
    end

    always_comb begin
      rem_q[s+1] = rem_r;
      quo_q[s+1] = quo_r;
      den_q[s+1] = den_r;
      tag_q[s+1] = tag_r;
      vld_q[s+1] = vld_r;
    end
  end

  assign valid_o = vld_q[Stages];
  assign quo_o   = {1'b0, quo_q[Stages]};
  assign tag_o   = tag_q[Stages];

endmodule

[hw/rtl/selector_shape_weight_top.sv]
// Input words pass the stage 0, divider, A, B and output registers in order.
// Throughput: one word per cycle; the divider stages and multiplier stages
// all advance together whenever the output register is free or being taken.
// A stall holds the whole pipeline in place.
// Reset clears all valid bits and loads the default configuration.
// ----------------------------------------------------------------------------
// Selector shape weight top level
// Maps a unit position to an envelope weight over a configured range.
// ----------------------------------------------------------------------------
module selector_shape_weight_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ssw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [FRAC_BITS:0]           cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [FRAC_BITS:0]           unit_position_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [FRAC_BITS:0]           weight_o
);

  localparam int unsigned W = FRAC_BITS + 1;
  localparam logic [W-1:0] One  = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] Half = W'(1) << (FRAC_BITS - 1);
  // Tag: mode(3), special(1), special value(1).
  localparam int unsigned TagW = ssw_pkg::ModeW + 2;
  localparam int unsigned PW = 2 * W + 2 - FRAC_BITS;

  logic [ssw_pkg::ModeW-1:0] mode_q;
  logic [W-1:0]              start_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      start_q <= '0;
      end_q   <= One;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ssw_pkg::REG_SHAPE_MODE:  mode_q  <= cfg_data_i[ssw_pkg::ModeW-1:0];
        ssw_pkg::REG_RANGE_START: start_q <= cfg_data_i;
        ssw_pkg::REG_RANGE_END:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register can take a word.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Stage 0: saturate, order the range and classify the position.
  logic [W-1:0] s_sat, e_sat, p_sat, s_lo, e_hi, p_m;
  logic         pre_special, pre_one;
  always_comb begin
    s_sat = (start_q > One) ? One : start_q;
    e_sat = (end_q > One) ? One : end_q;
    p_sat = (unit_position_i > One) ? One : unit_position_i;
    if (s_sat > e_sat) begin
      s_lo = e_sat;
      e_hi = s_sat;
      p_m  = One - p_sat;
    end else begin
      s_lo = s_sat;
      e_hi = e_sat;
      p_m  = p_sat;
    end
    pre_special = 1'b0;
    pre_one     = 1'b0;
    if (p_m <= s_lo) begin
      pre_special = 1'b1;
      pre_one     = (mode_q == ssw_pkg::SHAPE_RAMP_DN);
    end else if (p_m >= e_hi) begin
      pre_special = 1'b1;
      pre_one     = (mode_q == ssw_pkg::SHAPE_RAMP_UP);
    end
  end

  logic            p0_vld_q;
  logic [W-1:0]    p0_num_q, p0_den_q;
  logic [TagW-1:0] p0_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q <= 1'b0;
    end else if (adv) begin
      p0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_num_q <= p_m - s_lo;
      // A zero range only occurs in the special case; keep the divider sane.
      p0_den_q <= pre_special ? One : (e_hi - s_lo);
      p0_tag_q <= {mode_q, pre_special, pre_one};
    end
  end

  logic            dv_vld;
  logic [W-1:0]    dv_t;
  logic [TagW-1:0] dv_tag;

  ssw_divider #(
    .FRAC_BITS(FRAC_BITS),
    .BitsPerStage(4),
    .TagW(TagW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (p0_vld_q),
    .num_i   (p0_num_q),
    .den_i   (p0_den_q),
    .tag_i   (p0_tag_q),
    .valid_o (dv_vld),
    .quo_o   (dv_t),
    .tag_o   (dv_tag)
  );

  // Stage A: mirror, and first square or product.
  logic [W-1:0] u_a, v_a;
  always_comb begin
    u_a = (dv_t <= Half) ? (dv_t << 1) : ((One - dv_t) << 1);
    v_a = One - u_a;
  end

  logic            pa_vld_q;
  logic [W-1:0]    pa_t_q, pa_u_q, pa_v_q, pa_sq_q;
  logic [TagW-1:0] pa_tag_q;
  logic [W-1:0]    sq_in;
  logic [2*W-1:0]  sq_full;
  assign sq_in   = (dv_tag[TagW-1 -: ssw_pkg::ModeW] == ssw_pkg::SHAPE_SMOOTH) ? v_a : u_a;
  assign sq_full = {{W{1'b0}}, sq_in} * {{W{1'b0}}, sq_in};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_vld_q <= 1'b0;
    end else if (adv) begin
      pa_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_t_q   <= dv_t;
      pa_u_q   <= u_a;
      pa_v_q   <= v_a;
      pa_sq_q  <= sq_full[FRAC_BITS +: W];
      pa_tag_q <= dv_tag;
    end
  end

  // Stage B: second product.
  logic [W+1:0]    poly;
  logic [W+1:0]    mul_b;
  logic [2*W+1:0]  prod_b;
  assign poly  = {2'b00, One} + {1'b0, One, 1'b0} - {1'b0, pa_u_q, 1'b0};
  assign mul_b = (pa_tag_q[TagW-1 -: ssw_pkg::ModeW] == ssw_pkg::SHAPE_SMOOTH)
                 ? {2'b00, pa_v_q} : poly;
  assign prod_b = {{(W+2){1'b0}}, pa_sq_q} * {{W{1'b0}}, mul_b};

  logic            pb_vld_q;
  logic [W-1:0]    pb_t_q, pb_u_q, pb_p_q;
  logic [TagW-1:0] pb_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_vld_q <= 1'b0;
    end else if (adv) begin
      pb_vld_q <= pa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pb_t_q   <= pa_t_q;
      pb_u_q   <= pa_u_q;
      pb_p_q   <= (prod_b[2*W+1:FRAC_BITS] > PW'(One))
                  ? One : prod_b[FRAC_BITS +: W];
      pb_tag_q <= pa_tag_q;
    end
  end

  // Stage C: select the envelope and register the output word.
  logic [W-1:0] w_c;
  always_comb begin
    w_c = '0;
    if (pb_tag_q[1]) begin
      w_c = pb_tag_q[0] ? One : '0;
    end else begin
      case (pb_tag_q[TagW-1 -: ssw_pkg::ModeW])
        ssw_pkg::SHAPE_SQUARE:   w_c = One;
        ssw_pkg::SHAPE_RAMP_UP:  w_c = pb_t_q;
        ssw_pkg::SHAPE_RAMP_DN:  w_c = One - pb_t_q;
        ssw_pkg::SHAPE_TRIANGLE: w_c = pb_u_q;
        ssw_pkg::SHAPE_ROUND:    w_c = pb_p_q;
        ssw_pkg::SHAPE_SMOOTH:   w_c = One - pb_p_q;
        default:                 w_c = '0;
      endcase
    end
  end

  logic         out_vld_q;
  logic [W-1:0] weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= pb_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      weight_q <= (w_c > One) ? One : w_c;
    end
  end

  assign out_valid_o = out_vld_q;
  assign weight_o    = weight_q;

  property p_weight_bounded;
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> (weight_o <= One);
  endproperty
  a_weight_bounded: assert property (p_weight_bounded) else $error("weight above one");

  property p_stall_holds_pipe;
    @(posedge clk_i) disable iff (!rst_ni) (out_valid_o && out_stall_i) |=> out_valid_o;
  endproperty
  a_stall_holds_pipe: assert property (p_stall_holds_pipe) else $error("word lost in stall");

  property p_quotient_below_one;
    @(posedge clk_i) disable iff (!rst_ni) dv_vld |-> (dv_t < One);
  endproperty
  a_quotient_below_one: assert property (p_quotient_below_one) else $error("t out of range");

endmodule

[sim/selector_shape_weight_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Selector shape weight testbench
// Drives unit positions through the envelope block under several range and
// shape settings and idling patterns, predicts each weight and checks every
// output word in order against the prediction.
// ----------------------------------------------------------------------------
module selector_shape_weight_top_tb;

  localparam int unsigned FB = 16;
  localparam logic [FB:0] ONE = 17'(1 << FB);
  localparam logic [FB:0] HALF = 17'(1 << (FB - 1));
  localparam int unsigned WDOG_LIMIT = 20000;

  int unsigned n_errors = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    n_errors++;
  endtask

  class weight_board;
    logic [2:0]  mode;
    logic [FB:0] r_start;
    logic [FB:0] r_end;
    logic [FB:0] pending[$];

    function new();
      mode = ssw_pkg::SHAPE_SQUARE;
      r_start = '0;
      r_end = ONE;
    endfunction

    function automatic logic [FB:0] sat(input logic [FB:0] v);
      return (v > ONE) ? ONE : v;
    endfunction

    function automatic logic [FB:0] fold(input longint unsigned t);
      return (t <= HALF) ? 17'(t << 1) : 17'((ONE - t) << 1);
    endfunction

    function automatic logic [FB:0] envelope(input logic [FB:0] pos_in);
      longint unsigned p, s, e, rng, t, u, u2, v, v2, v3, w;
      p = sat(pos_in);
      s = sat(r_start);
      e = sat(r_end);
      if (s > e) begin
        rng = s; s = e; e = rng;
        p = ONE - p;
      end
      if (p <= s) return (mode == ssw_pkg::SHAPE_RAMP_DN) ? ONE : '0;
      if (p >= e) return (mode == ssw_pkg::SHAPE_RAMP_UP) ? ONE : '0;
      rng = e - s;
      t = (rng != 0) ? (((p - s) << FB) / rng) : HALF;
      if (t > ONE) t = ONE;
      case (mode)
        ssw_pkg::SHAPE_SQUARE: w = ONE;
        ssw_pkg::SHAPE_RAMP_UP: w = t;
        ssw_pkg::SHAPE_RAMP_DN: w = ONE - t;
        ssw_pkg::SHAPE_TRIANGLE: w = fold(t);
        ssw_pkg::SHAPE_ROUND: begin
          u = fold(t);
          u2 = (u * u) >> FB;
          w = (u2 * (3 * ONE - 2 * u)) >> FB;
        end
        ssw_pkg::SHAPE_SMOOTH: begin
          u = fold(t);
          v = ONE - u;
          v2 = (v * v) >> FB;
          v3 = (v2 * v) >> FB;
          w = ONE - v3;
        end
        default: w = 0;
      endcase
      if (w > ONE) w = ONE;
      return 17'(w);
    endfunction

    function void note_position(input logic [FB:0] pos);
      pending.push_back(envelope(pos));
    endfunction

    task check_weight(input logic [FB:0] got);
      logic [FB:0] want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected weight %0d", got));
      end else begin
        want = pending.pop_front();
        if (got !== want)
          report_mismatch($sformatf("weight %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [FB:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [FB:0] unit_position_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [FB:0] weight_o;

  weight_board board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int unsigned quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  selector_shape_weight_top #(.FRAC_BITS(FB)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .unit_position_i(unit_position_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .weight_o(weight_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_weight(weight_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input ssw_pkg::reg_idx_e idx, input logic [FB:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ssw_pkg::REG_SHAPE_MODE: board.mode = val[2:0];
      ssw_pkg::REG_RANGE_START: board.r_start = val;
      ssw_pkg::REG_RANGE_END: board.r_end = val;
      default: ;
    endcase
  endtask

  task automatic set_shape(input logic [2:0] m, input logic [FB:0] s, input logic [FB:0] e);
    write_reg(ssw_pkg::REG_SHAPE_MODE, {14'd0, m});
    write_reg(ssw_pkg::REG_RANGE_START, s);
    write_reg(ssw_pkg::REG_RANGE_END, e);
  endtask

  task automatic send_word(input logic [FB:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    unit_position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    board.note_position(pos);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [FB:0] rand_q();
    int unsigned k;
    k = $urandom_range(9);
    if (k == 0) return ONE;
    if (k == 1) return '0;
    if (k == 2) return 17'($urandom_range(131071));
    return 17'($urandom_range(65536));
  endfunction

  task automatic random_phase(input int unsigned n);
    logic [2:0] m;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        drain();
        m = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        set_shape(m, rand_q(), rand_q());
      end
      send_word(rand_q());
    end
  endtask

  initial begin
    logic [FB:0] edge_pos[$];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    edge_pos = '{17'd0, 17'd1, 17'h0C000, 17'h08000, 17'h10000, 17'h1FFFF, 17'h12345};
    foreach (edge_pos[i]) send_word(edge_pos[i]);
    drain();
    set_shape(ssw_pkg::SHAPE_SMOOTH, 17'h0C000, 17'h04000);
    foreach (edge_pos[i]) send_word(edge_pos[i]);
    drain();
    for (int m = 0; m < 8; m++) begin
      set_shape(3'(m), 17'h04000, 17'h1FFFF);
      send_word(17'h06000);
      send_word(17'h0E000);
      drain();
    end
    set_shape(ssw_pkg::SHAPE_ROUND, 17'h08000, 17'h08000);
    send_word(17'h08000);
    send_word(17'h09000);
    drain();
    write_reg(ssw_pkg::REG_SHAPE_MODE, 17'h1FFFD);

    random_phase(400);
    drain();
    send_idle_pct = 84;
    random_phase(300);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 84;
    random_phase(300);
    drain();
    send_idle_pct = 10;
    recv_stall_pct = 10;
    random_phase(300);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(200);
    join
    drain();
    repeat (20) @(posedge clk_i);
    if (n_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/ssw_pkg.sv
hw/rtl/ssw_divider.sv
hw/rtl/selector_shape_weight_top.sv
sim/selector_shape_weight_top_tb.sv
